FILE: design/abe_pkg.sv
package abe_pkg;

   localparam int REG_COUNT = 16;
   localparam int REG_W     = 4;
   localparam int DATA_W    = 32;

   localparam logic [REG_W-1:0] REG_PC   = 4'd15;
   localparam logic [REG_W-1:0] REG_LINK = 4'd14;

   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [DATA_W-1:0] MUL_MASK   = 32'h0fc0_00f0;
   localparam logic [DATA_W-1:0] MUL_MATCH  = 32'h0000_0090;
   localparam logic [DATA_W-1:0] BR_MASK    = 32'h0e00_0000;
   localparam logic [DATA_W-1:0] BR_MATCH   = 32'h0a00_0000;
   localparam logic [DATA_W-1:0] OFS_MASK   = 32'h00ff_ffff;
   localparam logic [DATA_W-1:0] OFS_SIGN   = 32'h0080_0000;
   localparam logic [DATA_W-1:0] OFS_EXTEND = 32'hfc00_0000;
   localparam logic [DATA_W-1:0] LINK_BACK  = 32'h0000_0004;

   typedef enum logic [2:0] {
      ST_MUL     = 3'd0,
      ST_BRANCH  = 3'd1,
      ST_ILLEGAL = 3'd2,
      ST_NOEXEC  = 3'd3,
      ST_ACCESS  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [DATA_W-1:0] instr;
      logic [REG_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_value;
   } req_beat_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
   } flags_type;

   typedef struct packed {
      status_type        status;
      logic [REG_W-1:0]  dest_index;
      logic [DATA_W-1:0] dest_value;
      logic              link_written;
      logic [DATA_W-1:0] link_value;
      flags_type         flags;
   } rsp_beat_type;

   // state updates produced by one executed beat
   typedef struct packed {
      logic              wr_en;
      logic [REG_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              pc_we;
      logic [DATA_W-1:0] pc_next;
      logic              flags_we;
   } upd_type;

   typedef struct packed {
      logic [REG_W-1:0] rs;
      logic [REG_W-1:0] rm;
      logic [REG_W-1:0] aux;
   } addr_type;

   // register file addresses a beat reads; aux is rn, or reg_index for a read
   function automatic addr_type op_addr(req_beat_type b);
      addr_type a;
      a.rs  = b.instr[11:8];
      a.rm  = b.instr[3:0];
      a.aux = (b.cmd == CMD_READ) ? b.reg_index : b.instr[15:12];
      return a;
   endfunction

endpackage

FILE: design/abe_if.sv
interface abe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] instr;
   logic [3:0]  reg_index;
   logic [31:0] write_value;

   modport source (output valid, cmd, instr, reg_index, write_value, input ready);
   modport sink (input valid, cmd, instr, reg_index, write_value, output ready);
endinterface

interface abe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  dest_index;
   logic [31:0] dest_value;
   logic        link_written;
   logic [31:0] link_value;
   logic        flag_n;
   logic        flag_z;
   logic        flag_c;

   modport source (output valid, status, dest_index, dest_value, link_written, link_value,
                   flag_n, flag_z, flag_c, input ready);
   modport sink (input valid, status, dest_index, dest_value, link_written, link_value,
                 flag_n, flag_z, flag_c, output ready);
endinterface

FILE: design/abe_ram.sv
module abe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int READS = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr [READS],
   output logic [WIDTH-1:0]         rd_data [READS]
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff [READS];

   // read-first: a read at the write address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      for (int i = 0; i < READS; i++) begin
         if (rd_en) begin
            rd_data_ff[i] <= mem_ff[rd_addr[i]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/abe_exec.sv
module abe_exec import abe_pkg::*; (
   input  req_beat_type      item,
   input  logic [DATA_W-1:0] rs_val,
   input  logic [DATA_W-1:0] rm_val,
   input  logic [DATA_W-1:0] aux_val,
   input  logic [DATA_W-1:0] pc_val,
   input  flags_type         flags,
   output rsp_beat_type      rsp,
   output upd_type           upd
);

   logic              is_mul;
   logic              is_br;
   logic              illegal;
   logic [REG_W-1:0]  rd;
   logic [REG_W-1:0]  rn;
   logic [DATA_W-1:0] prod;
   logic [DATA_W-1:0] mac;
   logic [DATA_W-1:0] ofs;
   logic [DATA_W-1:0] link;
   flags_type         mul_flags;

   always_comb begin
      is_mul  = (item.instr & MUL_MASK) == MUL_MATCH;
      is_br   = (item.instr & BR_MASK) == BR_MATCH;
      rd      = item.instr[19:16];
      rn      = item.instr[15:12];
      illegal = (rd == REG_PC) || (rn == REG_PC) || (item.instr[11:8] == REG_PC) ||
                (item.instr[3:0] == REG_PC) || (rd == item.instr[3:0]);
      prod    = rs_val * rm_val;
      mac     = prod + (item.instr[21] ? aux_val : '0);
      mul_flags.z = (mac == '0);
      mul_flags.n = mac[31];
      mul_flags.c = mac[2];
      ofs  = ((item.instr & OFS_MASK) << 2) | ((item.instr & OFS_SIGN) != '0 ? OFS_EXTEND : '0);
      link = pc_val - LINK_BACK;

      rsp = '{status: ST_NOEXEC, dest_index: '0, dest_value: '0, link_written: 1'b0,
              link_value: '0, flags: flags};
      upd = '{wr_en: 1'b0, wr_addr: '0, wr_data: '0, pc_we: 1'b0, pc_next: pc_val,
              flags_we: 1'b0};

      case (item.cmd)
         CMD_EXEC: begin
            if (is_mul) begin
               if (illegal) begin
                  rsp.status = ST_ILLEGAL;
               end else begin
                  rsp.status     = ST_MUL;
                  rsp.dest_index = rd;
                  rsp.dest_value = mac;
                  upd.wr_en      = 1'b1;
                  upd.wr_addr    = rd;
                  upd.wr_data    = mac;
                  if (item.instr[20]) begin
                     upd.flags_we = 1'b1;
                     rsp.flags    = mul_flags;
                  end
               end
            end else if (is_br) begin
               rsp.status     = ST_BRANCH;
               rsp.dest_index = REG_PC;
               rsp.dest_value = pc_val + ofs;
               upd.pc_we      = 1'b1;
               upd.pc_next    = pc_val + ofs;
               if (item.instr[24]) begin
                  rsp.link_written = 1'b1;
                  rsp.link_value   = link;
                  upd.wr_en        = 1'b1;
                  upd.wr_addr      = REG_LINK;
                  upd.wr_data      = link;
               end
            end
         end
         CMD_WRITE: begin
            rsp.status     = ST_ACCESS;
            rsp.dest_index = item.reg_index;
            rsp.dest_value = item.write_value;
            if (item.reg_index == REG_PC) begin
               upd.pc_we   = 1'b1;
               upd.pc_next = item.write_value;
            end else begin
               upd.wr_en   = 1'b1;
               upd.wr_addr = item.reg_index;
               upd.wr_data = item.write_value;
            end
         end
         CMD_READ: begin
            rsp.status     = ST_ACCESS;
            rsp.dest_index = item.reg_index;
            rsp.dest_value = (item.reg_index == REG_PC) ? pc_val : aux_val;
         end
         default: begin
            rsp.status = ST_NOEXEC;
         end
      endcase
   end

endmodule

FILE: design/arm_multiply_branch_execute.sv
// Flow: a beat accepted into s1 is executed in the next cycle, and its result is
// registered as the result beat when s1 advances. Throughput: one beat per clock unless
// the result channel stalls, set by the register file read / execute / write loop,
// which closes through a one-entry write bypass in front of the operand RAMs.
// Reset: clears pipeline valids, flags, r15 and the per-register valid bits, so the
// whole register file reads as zero at once; no clearing pass.
module arm_multiply_branch_execute import abe_pkg::*; (
   input logic        clock,
   input logic        reset,
   abe_req_if.sink    req_chan,
   abe_rsp_if.source  rsp_chan
);

   req_beat_type      req_beat;
   addr_type          req_addr;
   addr_type          s1_addr;
   logic              accept;
   logic              s1_adv;

   logic              s1_valid_ff, s1_valid_in;
   req_beat_type      s1_item_ff, s1_item_in;
   logic [2:0]        s1_vld_ff, s1_vld_in;
   logic [REG_COUNT-1:0] rf_valid_ff, rf_valid_in;
   logic              wb_en_ff, wb_en_in;
   logic [REG_W-1:0]  wb_addr_ff, wb_addr_in;
   logic [DATA_W-1:0] wb_data_ff, wb_data_in;
   logic [DATA_W-1:0] pc_ff, pc_in;
   flags_type         flags_ff, flags_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_beat_type      rsp_beat_ff, rsp_beat_in;

   logic [REG_W-1:0]  bank_a_addr [2];
   logic [DATA_W-1:0] bank_a_data [2];
   logic [REG_W-1:0]  bank_b_addr [1];
   logic [DATA_W-1:0] bank_b_data [1];

   logic [DATA_W-1:0] rs_val;
   logic [DATA_W-1:0] rm_val;
   logic [DATA_W-1:0] aux_val;
   rsp_beat_type      exec_rsp;
   upd_type           upd;

   assign req_beat = '{cmd: req_chan.cmd, instr: req_chan.instr,
                       reg_index: req_chan.reg_index, write_value: req_chan.write_value};
   assign req_addr = op_addr(req_beat);
   assign s1_addr  = op_addr(s1_item_ff);

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   assign bank_a_addr[0] = req_addr.rs;
   assign bank_a_addr[1] = req_addr.rm;
   assign bank_b_addr[0] = req_addr.aux;

   // two copies of the register file, written alike, give three read ports
   abe_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT), .READS(2)) u_bank_a (
      .clock   (clock),
      .wr_en   (s1_adv && upd.wr_en),
      .wr_addr (upd.wr_addr),
      .wr_data (upd.wr_data),
      .rd_en   (accept),
      .rd_addr (bank_a_addr),
      .rd_data (bank_a_data)
   );

   abe_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT), .READS(1)) u_bank_b (
      .clock   (clock),
      .wr_en   (s1_adv && upd.wr_en),
      .wr_addr (upd.wr_addr),
      .wr_data (upd.wr_data),
      .rd_en   (accept),
      .rd_addr (bank_b_addr),
      .rd_data (bank_b_data)
   );

   // the write landing on the read edge is not in the RAM word yet: bypass it
   always_comb begin
      if (wb_en_ff && wb_addr_ff == s1_addr.rs) begin
         rs_val = wb_data_ff;
      end else begin
         rs_val = s1_vld_ff[2] ? bank_a_data[0] : '0;
      end
      if (wb_en_ff && wb_addr_ff == s1_addr.rm) begin
         rm_val = wb_data_ff;
      end else begin
         rm_val = s1_vld_ff[1] ? bank_a_data[1] : '0;
      end
      if (wb_en_ff && wb_addr_ff == s1_addr.aux) begin
         aux_val = wb_data_ff;
      end else begin
         aux_val = s1_vld_ff[0] ? bank_b_data[0] : '0;
      end
   end

   abe_exec u_exec (
      .item    (s1_item_ff),
      .rs_val  (rs_val),
      .rm_val  (rm_val),
      .aux_val (aux_val),
      .pc_val  (pc_ff),
      .flags   (flags_ff),
      .rsp     (exec_rsp),
      .upd     (upd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      s1_vld_in   = s1_vld_ff;
      rf_valid_in = rf_valid_ff;
      wb_en_in    = wb_en_ff;
      wb_addr_in  = wb_addr_ff;
      wb_data_in  = wb_data_ff;
      pc_in       = pc_ff;
      flags_in    = flags_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_valid_in  = 1'b0;
         wb_en_in     = upd.wr_en;
         wb_addr_in   = upd.wr_addr;
         wb_data_in   = upd.wr_data;
         if (upd.wr_en) begin
            rf_valid_in[upd.wr_addr] = 1'b1;
         end
         if (upd.pc_we) begin
            pc_in = upd.pc_next;
         end
         if (upd.flags_we) begin
            flags_in = exec_rsp.flags;
         end
         rsp_valid_in = 1'b1;
         rsp_beat_in  = exec_rsp;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_beat;
         s1_vld_in   = {rf_valid_ff[req_addr.rs], rf_valid_ff[req_addr.rm],
                        rf_valid_ff[req_addr.aux]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rf_valid_ff  <= '0;
         wb_en_ff     <= 1'b0;
         pc_ff        <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rf_valid_ff  <= rf_valid_in;
         wb_en_ff     <= wb_en_in;
         pc_ff        <= pc_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      s1_vld_ff   <= s1_vld_in;
      wb_addr_ff  <= wb_addr_in;
      wb_data_ff  <= wb_data_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_beat_ff.status;
   assign rsp_chan.dest_index   = rsp_beat_ff.dest_index;
   assign rsp_chan.dest_value   = rsp_beat_ff.dest_value;
   assign rsp_chan.link_written = rsp_beat_ff.link_written;
   assign rsp_chan.link_value   = rsp_beat_ff.link_value;
   assign rsp_chan.flag_n       = rsp_beat_ff.flags.n;
   assign rsp_chan.flag_z       = rsp_beat_ff.flags.z;
   assign rsp_chan.flag_c       = rsp_beat_ff.flags.c;

   a_illegal_no_update: assert property (@(posedge clock) disable iff (reset)
      s1_adv && exec_rsp.status == ST_ILLEGAL |-> !upd.wr_en && !upd.pc_we && !upd.flags_we)
      else $error("illegal multiply updates state");

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> rf_valid_ff == '0 && !s1_valid_ff && !rsp_valid_ff)
      else $error("reset left register valid bits or pipeline valid set");

   a_pc_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && upd.pc_we) |=> $stable(pc_ff))
      else $error("r15 changed without branch or write");

   a_flags_only_on_mul_s: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && upd.flags_we) |=> $stable(flags_ff))
      else $error("flags changed without a flag-setting multiply");

   a_adv_loads_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff && rsp_beat_ff == $past(exec_rsp))
      else $error("executed beat did not reach the result register");

endmodule

FILE: tb/sv/arm_multiply_branch_execute_test.sv
`timescale 1ns / 1ps

module arm_multiply_branch_execute_test;
   import abe_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_BEATS    = 360;
   localparam int PRESSURE_BEATS = 60;

   typedef struct {
      req_beat_type beat;
      bit           typed;
      rsp_beat_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   abe_req_if req_chan();
   abe_rsp_if rsp_chan();

   arm_multiply_branch_execute uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic         req_valid_q = 1'b0;
   req_beat_type req_drive   = '0;
   logic         rsp_ready_q = 1'b0;

   assign req_chan.valid       = req_valid_q;
   assign req_chan.cmd         = req_drive.cmd;
   assign req_chan.instr       = req_drive.instr;
   assign req_chan.reg_index   = req_drive.reg_index;
   assign req_chan.write_value = req_drive.write_value;
   assign rsp_chan.ready       = rsp_ready_q;

   // shadow register file and flags
   logic [DATA_W-1:0] gpr_model [REG_COUNT];
   flags_type         flag_model;

   rsp_beat_type exp_rsp_q [$];
   dir_row_type  dir_rows [$];

   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int quiet       = 0;
   int mismatches  = 0;
   int beats_sent  = 0;
   int rsp_checked = 0;
   int status_seen [5];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] mul_word(input logic [3:0] cond, input bit acc,
                                            input bit setf, input logic [3:0] rd,
                                            input logic [3:0] rn, input logic [3:0] rs,
                                            input logic [3:0] rm);
      return {cond, 6'b000000, acc, setf, rd, rn, rs, 4'b1001, rm};
   endfunction

   function automatic logic [31:0] br_word(input logic [3:0] cond, input bit link,
                                           input logic [23:0] ofs);
      return {cond, 3'b101, link, ofs};
   endfunction

   function automatic void dir_add(input logic [1:0] cmd, input logic [31:0] instr,
                                   input logic [3:0] idx, input logic [31:0] val,
                                   input bit typed, input status_type st,
                                   input logic [3:0] di, input logic [31:0] dv);
      dir_row_type row;
      row.beat.cmd         = cmd;
      row.beat.instr       = instr;
      row.beat.reg_index   = idx;
      row.beat.write_value = val;
      row.typed            = typed;
      row.want             = '0;
      row.want.status      = st;
      row.want.dest_index  = di;
      row.want.dest_value  = dv;
      dir_rows.push_back(row);
   endfunction

   // executes one beat against the shadow state and returns its result
   task automatic exec_model(input req_beat_type b, output rsp_beat_type r);
      logic [3:0]  rd, rn, rs, rm;
      logic [31:0] prod, ofs, lv;
      r = '0;
      r.status = ST_NOEXEC;
      case (b.cmd)
         CMD_EXEC: begin
            rd = b.instr[19:16];
            rn = b.instr[15:12];
            rs = b.instr[11:8];
            rm = b.instr[3:0];
            if ((b.instr & MUL_MASK) == MUL_MATCH) begin
               // rn is checked even for plain MUL
               if (rd == REG_PC || rn == REG_PC || rs == REG_PC || rm == REG_PC
                   || rd == rm) begin
                  r.status = ST_ILLEGAL;
               end else begin
                  prod = gpr_model[rs] * gpr_model[rm];
                  if (b.instr[21])
                     prod = prod + gpr_model[rn];
                  gpr_model[rd] = prod;
                  if (b.instr[20]) begin
                     flag_model.z = (prod == 32'h0);
                     flag_model.n = prod[31];
                     flag_model.c = prod[2];
                  end
                  r.status     = ST_MUL;
                  r.dest_index = rd;
                  r.dest_value = prod;
               end
            end else if ((b.instr & BR_MASK) == BR_MATCH) begin
               ofs = {{6{b.instr[23]}}, b.instr[23:0], 2'b00};
               if (b.instr[24]) begin
                  lv = gpr_model[REG_PC] - LINK_BACK;
                  gpr_model[REG_LINK] = lv;
                  r.link_written = 1'b1;
                  r.link_value   = lv;
               end
               gpr_model[REG_PC] = gpr_model[REG_PC] + ofs;
               r.status     = ST_BRANCH;
               r.dest_index = REG_PC;
               r.dest_value = gpr_model[REG_PC];
            end
         end
         CMD_WRITE: begin
            gpr_model[b.reg_index] = b.write_value;
            r.status     = ST_ACCESS;
            r.dest_index = b.reg_index;
            r.dest_value = b.write_value;
         end
         CMD_READ: begin
            r.status     = ST_ACCESS;
            r.dest_index = b.reg_index;
            r.dest_value = gpr_model[b.reg_index];
         end
         default: begin
         end
      endcase
      r.flags = flag_model;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   function automatic req_beat_type rand_beat();
      req_beat_type b;
      logic [3:0]   rd, rn, rs, rm;
      int           kind;
      b.cmd         = 2'($urandom);
      b.instr       = $urandom;
      b.reg_index   = 4'($urandom);
      b.write_value = pick_value();
      kind          = $urandom_range(99);
      if (kind < 22) begin
         b.cmd = CMD_WRITE;
      end else if (kind < 35) begin
         b.cmd = CMD_READ;
      end else if (kind < 70) begin
         // legal operands most of the time; rd differs from rm unless the illegal pick sets it equal
         rm = 4'($urandom_range(14));
         rd = 4'((rm + 1 + $urandom_range(13)) % 15);
         rn = 4'($urandom_range(14));
         rs = 4'($urandom_range(14));
         case ($urandom_range(15))
            0: rd = REG_PC;
            1: rn = REG_PC;
            2: rs = REG_PC;
            3: rm = REG_PC;
            4: rd = rm;
            default: begin
            end
         endcase
         b.cmd   = CMD_EXEC;
         b.instr = mul_word(4'($urandom), 1'($urandom), 1'($urandom), rd, rn, rs, rm);
      end else if (kind < 85) begin
         b.cmd   = CMD_EXEC;
         b.instr = br_word(4'($urandom), 1'($urandom),
                           ($urandom_range(3) == 0) ? 24'($urandom_range(7)) - 24'd4
                                                    : 24'($urandom));
      end else if (kind < 95) begin
         b.cmd = CMD_EXEC;
      end else begin
         b.cmd = CMD_UNUSED;
      end
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b, input bit typed,
                            input rsp_beat_type want);
      rsp_beat_type guess;
      while ($urandom_range(99) < idle_pct) begin
         req_valid_q <= 1'b0;
         @(posedge clock);
      end
      req_valid_q <= 1'b1;
      req_drive   <= b;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      exec_model(b, guess);
      exp_rsp_q.push_back(typed ? want : guess);
      beats_sent++;
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", fname, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_beat_type want;
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_ready_q) begin
            if (exp_rsp_q.size() == 0) begin
               $error("result beat with nothing expected, status %0d", rsp_chan.status);
               mismatches++;
            end else begin
               want = exp_rsp_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_chan.status));
               check_field("dest_index", 32'(want.dest_index), 32'(rsp_chan.dest_index));
               check_field("dest_value", want.dest_value, rsp_chan.dest_value);
               check_field("link_written", 32'(want.link_written),
                           32'(rsp_chan.link_written));
               check_field("link_value", want.link_value, rsp_chan.link_value);
               check_field("flag_n", 32'(want.flags.n), 32'(rsp_chan.flag_n));
               check_field("flag_z", 32'(want.flags.z), 32'(rsp_chan.flag_z));
               check_field("flag_c", 32'(want.flags.c), 32'(rsp_chan.flag_c));
               status_seen[int'(want.status)]++;
               rsp_checked++;
            end
         end
         // long hold-off so the block backs up into its input
         if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            rsp_ready_q <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            rsp_ready_q <= 1'b0;
         end else begin
            rsp_ready_q <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid_q && req_chan.ready === 1'b1)
          || (rsp_chan.valid === 1'b1 && rsp_ready_q)) begin
         quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int idle_tab [4];
      int stall_tab [4];
      idle_tab  = '{0, 61, 0, 7};
      stall_tab = '{0, 0, 61, 7};
      foreach (gpr_model[i])
         gpr_model[i] = '0;
      flag_model = '0;

      // typed rows come before any executed flag-setting multiply, so flags read zero
      dir_add(CMD_READ, 32'h0, 4'd0, 32'h0, 1'b1, ST_ACCESS, 4'd0, 32'h0);
      dir_add(CMD_READ, 32'hffff_ffff, REG_PC, 32'hffff_ffff, 1'b1, ST_ACCESS, REG_PC, 32'h0);
      dir_add(CMD_WRITE, 32'h0, 4'd1, 32'hffff_ffff, 1'b1, ST_ACCESS, 4'd1, 32'hffff_ffff);
      dir_add(CMD_WRITE, 32'h0, 4'd2, 32'hffff_ffff, 1'b1, ST_ACCESS, 4'd2, 32'hffff_ffff);
      dir_add(CMD_WRITE, 32'h0, 4'd4, 32'h8000_0000, 1'b1, ST_ACCESS, 4'd4, 32'h8000_0000);
      dir_add(CMD_WRITE, 32'h0, 4'd7, 32'h4, 1'b1, ST_ACCESS, 4'd7, 32'h4);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b0, 1'b1, REG_PC, 4'd0, 4'd1, 4'd2), 4'd0, 32'h0,
              1'b1, ST_ILLEGAL, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b0, 1'b1, 4'd3, REG_PC, 4'd1, 4'd2), 4'd0, 32'h0,
              1'b1, ST_ILLEGAL, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b1, 1'b1, 4'd3, 4'd0, REG_PC, 4'd2), 4'd0, 32'h0,
              1'b1, ST_ILLEGAL, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b0, 1'b1, 4'd3, 4'd0, 4'd1, REG_PC), 4'd0, 32'h0,
              1'b1, ST_ILLEGAL, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b1, 1'b1, 4'd3, 4'd0, 4'd1, 4'd3), 4'd0, 32'h0,
              1'b1, ST_ILLEGAL, 4'd0, 32'h0);
      dir_add(CMD_EXEC, 32'h0, 4'd0, 32'h0, 1'b1, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, 32'hffff_ffff, 4'd15, 32'h0, 1'b1, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_UNUSED, mul_word(4'hE, 1'b0, 1'b1, 4'd3, 4'd0, 4'd1, 4'd2), 4'd5,
              32'h1234_5678, 1'b1, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b0, 1'b1, 4'd3, 4'd0, 4'd1, 4'd2), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b0, 1'b1, 4'd5, 4'd0, 4'd4, 4'd1), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b1, 1'b1, 4'd6, 4'd0, 4'd0, 4'd1), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b1, 1'b1, 4'd8, 4'd7, 4'd0, 4'd1), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, mul_word(4'hE, 1'b1, 1'b0, 4'd9, 4'd5, 4'd1, 4'd4), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, br_word(4'hE, 1'b0, 24'h7f_ffff), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, br_word(4'hE, 1'b1, 24'hff_ffff), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, br_word(4'h0, 1'b1, 24'h80_0000), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_EXEC, br_word(4'hF, 1'b0, 24'h0), 4'd0, 32'h0,
              1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_READ, 32'h0, REG_LINK, 32'h0, 1'b0, ST_NOEXEC, 4'd0, 32'h0);
      dir_add(CMD_READ, 32'h0, REG_PC, 32'h0, 1'b0, ST_NOEXEC, 4'd0, 32'h0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_tab[p];
         stall_pct <= stall_tab[p];
         repeat (PHASE_BEATS)
            send_beat(rand_beat(), 1'b0, '0);
      end

      // sender keeps offering while the receiver holds off
      idle_pct   = 0;
      stall_pct  <= 0;
      hold_token <= hold_token + 1;
      repeat (PRESSURE_BEATS)
         send_beat(rand_beat(), 1'b0, '0);

      req_valid_q <= 1'b0;
      while (exp_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats (directed, four idle/stall mixes, one long hold-off);",
               beats_sent);
      $display("checked %0d results: mul %0d, branch %0d, illegal %0d, not run %0d, access %0d",
               rsp_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (mismatches == 0 && exp_rsp_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/abe_pkg.sv
design/abe_if.sv
design/abe_ram.sv
design/abe_exec.sv
design/arm_multiply_branch_execute.sv
tb/sv/arm_multiply_branch_execute_test.sv
